FILE: rtl/spms_pkg.sv
package spms_pkg;

  // Fixed widths of the stream and configuration fields.
  localparam int unsigned TextByteW = 8;
  localparam int unsigned MatchW    = 32;
  localparam int unsigned CfgDataW  = 64;
  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned LenW      = 6;

  // Bytes carried by one pattern word register.
  localparam int unsigned BytesPerWord = CfgDataW / TextByteW;

  // Defaults for the top-level parameters.
  localparam int unsigned MaxPatternDefault   = 32;
  localparam int unsigned PositionBitsDefault = 32;

  // Configuration register indexes.
  localparam logic [CfgIndexW-1:0] CFG_PAT_0_7   = 3'd0;
  localparam logic [CfgIndexW-1:0] CFG_PAT_8_15  = 3'd1;
  localparam logic [CfgIndexW-1:0] CFG_PAT_16_23 = 3'd2;
  localparam logic [CfgIndexW-1:0] CFG_PAT_24_31 = 3'd3;
  localparam logic [CfgIndexW-1:0] CFG_LENGTH    = 3'd4;

  // One result item.
  typedef struct packed {
    logic [MatchW-1:0] match_start;
    logic [MatchW-1:0] match_end;
  } match_t;

endpackage

FILE: rtl/spms_text_if.sv
interface spms_text_if import spms_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [TextByteW-1:0] text_byte;
  logic                 new_text;

  modport source (output valid, output text_byte, output new_text, input ready);
  modport sink   (input valid, input text_byte, input new_text, output ready);
endinterface

FILE: rtl/spms_match_if.sv
interface spms_match_if import spms_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MatchW-1:0] match_start;
  logic [MatchW-1:0] match_end;

  modport source (output valid, output match_start, output match_end, input ready);
  modport sink   (input valid, input match_start, input match_end, output ready);
endinterface

FILE: rtl/spms_cfg_if.sv
interface spms_cfg_if import spms_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CfgIndexW-1:0] index;
  logic [CfgDataW-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/stream_pattern_match_scanner_core.sv
// The text channel (text_i) carries one text byte per transfer together with
// a new_text flag that marks position zero of a fresh text. The match channel
// (match_o) carries one transfer per completed match, giving the text
// positions of its first and last byte. The configuration channel (cfg_i)
// writes the four pattern word registers and the pattern length; it is
// always ready and should only be used while no text is in flight.
//
// A text byte is taken in every cycle while the output buffer has room. Each
// byte is compared in the cycle of its transfer against the current and the
// first pattern byte; the scan loop closes through a single byte compare. A
// match is registered into the output buffer as its last byte is taken.
//
// The output side is a two-entry buffer (an output register and a skid
// register), so text keeps flowing while one match waits to be taken. When
// the receiver stalls long enough for both entries to fill, text_i.ready
// drops until an entry drains.
//
// Reset clears the scan state, the text position and the output buffer, sets
// the pattern to all zero bytes and the pattern length to one.
module stream_pattern_match_scanner_core
  import spms_pkg::*;
#(
  parameter int unsigned MAX_PATTERN   = MaxPatternDefault,
  parameter int unsigned POSITION_BITS = PositionBitsDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  spms_text_if.sink    text_i,
  spms_match_if.source match_o,
  spms_cfg_if.sink     cfg_i
);

  localparam int unsigned PpW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam logic [LenW-1:0] MaxLen = LenW'(MAX_PATTERN);

  // Only the bytes that a scan can ever reach are stored.
  logic [TextByteW-1:0]     pat_q [MAX_PATTERN];
  logic [LenW-1:0]          len_q;

  logic                     in_match_q, in_match_d;
  logic [PpW-1:0]           pat_pos_q, pat_pos_d;
  logic [POSITION_BITS-1:0] text_pos_q, text_pos_d;
  logic [POSITION_BITS-1:0] cand_start_q, cand_start_d;

  logic                     main_v_q, skid_v_q;
  match_t                   main_q, skid_q;

  logic                     cfg_acc;
  logic                     text_acc;
  logic                     pop;
  logic                     found;
  logic [POSITION_BITS-1:0] pos;
  logic [POSITION_BITS-1:0] m_start;
  logic [POSITION_BITS-1:0] cand_base;
  logic                     in_match_base;
  logic [PpW-1:0]           pat_pos_base;
  logic [LenW-1:0]          len_eff;
  logic                     len_one;
  logic                     at_last;
  logic                     hit_first;
  logic                     hit_cur;
  match_t                   result;

  // Configuration writes; writes beyond the register list are dropped.
  assign cfg_i.ready = 1'b1;
  assign cfg_acc     = cfg_i.valid & cfg_i.ready;

  for (genvar b = 0; b < MAX_PATTERN; b++) begin : g_pat
    localparam logic [CfgIndexW-1:0] WordIdx = CfgIndexW'(b / BytesPerWord);
    localparam int unsigned          Lsb     = (b % BytesPerWord) * TextByteW;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        pat_q[b] <= '0;
      end else if (cfg_acc && cfg_i.index == WordIdx) begin
        pat_q[b] <= cfg_i.data[Lsb +: TextByteW];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= LenW'(1);
    end else if (cfg_acc && cfg_i.index == CFG_LENGTH) begin
      len_q <= cfg_i.data[LenW-1:0];
    end
  end

  // A length of zero acts as one, and anything past the pattern store is
  // clamped to its size.
  always_comb begin
    if (len_q == '0) begin
      len_eff = LenW'(1);
    end else if (len_q > MaxLen) begin
      len_eff = MaxLen;
    end else begin
      len_eff = len_q;
    end
  end

  assign len_one = (len_eff == LenW'(1));

  // A fresh text clears the scan before its first byte is compared.
  assign in_match_base = text_i.new_text ? 1'b0 : in_match_q;
  assign pat_pos_base  = text_i.new_text ? '0 : pat_pos_q;
  assign cand_base     = text_i.new_text ? '0 : cand_start_q;
  assign pos           = text_i.new_text ? '0 : text_pos_q;

  assign hit_first = (text_i.text_byte == pat_q[0]);
  assign hit_cur   = (text_i.text_byte == pat_q[pat_pos_base]);
  assign at_last   = (LenW'(pat_pos_base) >= (len_eff - LenW'(1)));

  // Scan step. Inside a candidate a mismatch only retries the first pattern
  // byte at the current position; it never backs up into the candidate.
  always_comb begin
    in_match_d   = in_match_base;
    pat_pos_d    = pat_pos_base;
    cand_start_d = cand_base;
    found        = 1'b0;
    m_start      = pos;
    if (!in_match_base) begin
      if (hit_first) begin
        if (len_one) begin
          found = 1'b1;
        end else begin
          in_match_d   = 1'b1;
          cand_start_d = pos;
          pat_pos_d    = PpW'(1);
        end
      end
    end else if (!hit_cur) begin
      pat_pos_d = '0;
      if (!hit_first) begin
        in_match_d = 1'b0;
      end else if (len_one) begin
        found      = 1'b1;
        in_match_d = 1'b0;
      end else begin
        cand_start_d = pos;
        pat_pos_d    = PpW'(1);
      end
    end else if (at_last) begin
      found      = 1'b1;
      m_start    = cand_base;
      pat_pos_d  = '0;
      in_match_d = 1'b0;
    end else begin
      pat_pos_d = pat_pos_base + PpW'(1);
    end
  end

  // The text position saturates at its all-ones value.
  assign text_pos_d = (pos == '1) ? pos : pos + POSITION_BITS'(1);

  assign result.match_start = MatchW'(m_start);
  assign result.match_end   = MatchW'(pos);

  assign text_i.ready = ~skid_v_q;
  assign text_acc     = text_i.valid & text_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_match_q   <= 1'b0;
      pat_pos_q    <= '0;
      text_pos_q   <= '0;
      cand_start_q <= '0;
    end else if (text_acc) begin
      in_match_q   <= in_match_d;
      pat_pos_q    <= pat_pos_d;
      text_pos_q   <= text_pos_d;
      cand_start_q <= cand_start_d;
    end
  end

  // Output buffer: the output register feeds match_o; the skid register
  // catches a match that arrives while the output register is held.
  assign pop = main_v_q & match_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (pop || !main_v_q) begin
      if (skid_v_q) begin
        main_v_q <= 1'b1;
        skid_v_q <= text_acc & found;
      end else begin
        main_v_q <= text_acc & found;
      end
    end else if (text_acc && found) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop || !main_v_q) begin
      if (skid_v_q) begin
        main_q <= skid_q;
        skid_q <= result;
      end else begin
        main_q <= result;
      end
    end else if (text_acc && found) begin
      skid_q <= result;
    end
  end

  assign match_o.valid       = main_v_q;
  assign match_o.match_start = main_q.match_start;
  assign match_o.match_end   = main_q.match_end;

  // The skid entry is only ever filled behind a held output register.
  a_skid_behind_main : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> main_v_q)
    else $error("skid register holds a match while the output register is empty");

  // Outside a candidate the pattern index rests at zero.
  a_idle_pat_pos : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_match_q |-> (pat_pos_q == '0))
    else $error("pattern index nonzero while scanning text");

  // A byte that starts a fresh text takes position zero.
  a_new_text_pos : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (text_acc && text_i.new_text) |=> (text_pos_q == POSITION_BITS'(1)))
    else $error("text position not restarted by a fresh text");

  // A full buffer stops text transfers.
  a_full_stops_text : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (main_v_q && skid_v_q) |-> !text_i.ready)
    else $error("text taken while the output buffer is full");

endmodule

FILE: tb/stream_pattern_match_scanner_core_test.sv
module stream_pattern_match_scanner_core_test;
  import spms_pkg::*;

  // Timing of the run. The watchdog only counts cycles in which no channel
  // moved a transfer, so long but healthy stretches never trip it.
  localparam int unsigned HalfPeriod    = 6;
  localparam int unsigned SettleCycles  = 4;
  localparam int unsigned HoldCycles    = 80;
  localparam int unsigned WatchdogLimit = 3000;
  localparam int unsigned SegItems      = 115;
  localparam int unsigned NumSegments   = 9;
  localparam int unsigned NumRows       = 36;

  // Register indexes past the last defined one. Writes to them must be
  // dropped by the block.
  localparam logic [CfgIndexW-1:0] CfgSpareLo = 3'd5;
  localparam logic [CfgIndexW-1:0] CfgSpareHi = 3'd7;

  typedef enum logic {ROW_TEXT, ROW_REG} row_kind_e;
  // How a directed text byte is checked: by the scan model, or against a
  // result typed into the table (a match, or no match at all).
  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_MATCH} check_e;

  typedef struct packed {
    row_kind_e                kind;
    logic [CfgIndexW-1:0]     index;
    logic [CfgDataW-1:0]      data;
    logic [TextByteW-1:0]     text_byte;
    logic                     new_text;
    check_e                   check;
    logic [MatchW-1:0]        first;
    logic [MatchW-1:0]        last;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  spms_text_if  text_ch ();
  spms_match_if match_ch ();
  spms_cfg_if   cfg_ch ();

  stream_pattern_match_scanner_core dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .text_i  (text_ch),
    .match_o (match_ch),
    .cfg_i   (cfg_ch)
  );

  // Our own copy of the pattern registers, as they stand after reset.
  logic [CfgDataW-1:0] pattern_word [4] = '{default: '0};
  logic [LenW-1:0]     pattern_len = 6'd1;

  // Our own copy of the scan state, also at its reset values.
  logic                in_candidate = 1'b0;
  logic [4:0]          cmp_index = '0;
  logic [MatchW-1:0]   next_pos = '0;
  logic [MatchW-1:0]   candidate_pos = '0;

  // Matches predicted but not yet seen on the match channel, oldest first.
  match_t pending_matches [$];

  int unsigned src_idle_pct = 0;
  int unsigned sink_stall_pct = 0;
  bit          hold_req = 1'b0;

  int unsigned bytes_sent = 0;
  int unsigned matches_seen = 0;
  int unsigned reg_writes = 0;
  int unsigned mismatches = 0;

  // Symbols used by the random text of one segment. A narrow alphabet makes
  // repeats and self-similar patterns common.
  logic [TextByteW-1:0] alpha_base;
  int unsigned          alpha_size;

  function automatic stim_row_t text_row(logic [TextByteW-1:0] b, logic nt,
                                         check_e chk = CHK_MODEL,
                                         logic [MatchW-1:0] s = '0,
                                         logic [MatchW-1:0] e = '0);
    stim_row_t r;
    r = '0;
    r.kind = ROW_TEXT;
    r.text_byte = b;
    r.new_text = nt;
    r.check = chk;
    r.first = s;
    r.last = e;
    return r;
  endfunction

  function automatic stim_row_t reg_row(logic [CfgIndexW-1:0] idx,
                                        logic [CfgDataW-1:0] d);
    stim_row_t r;
    r = '0;
    r.kind = ROW_REG;
    r.index = idx;
    r.data = d;
    r.check = CHK_NONE;
    return r;
  endfunction

  // Directed part. Right after reset the pattern is a single zero byte, so
  // every zero byte is a one-byte match at its own position. Later rows use
  // the pattern "ABCD..." to cover restarts on a mismatch, a fresh text in
  // the middle of a candidate, length values outside 1..32, and length
  // changes while a candidate is open.
  stim_row_t directed_rows [NumRows] = '{
    text_row(8'h00, 1'b1, CHK_MATCH, 32'd0, 32'd0),
    text_row(8'hFF, 1'b0, CHK_NONE),
    text_row(8'h00, 1'b0, CHK_MATCH, 32'd2, 32'd2),
    // Writes to unused indexes leave the pattern alone.
    reg_row(CfgSpareLo, '1),
    reg_row(CfgSpareHi, '1),
    text_row(8'h00, 1'b0, CHK_MATCH, 32'd3, 32'd3),
    // A length of zero behaves as a length of one.
    reg_row(CFG_LENGTH, 64'd0),
    text_row(8'h00, 1'b1, CHK_MATCH, 32'd0, 32'd0),
    reg_row(CFG_PAT_0_7,   64'h4847_4645_4443_4241),
    reg_row(CFG_PAT_8_15,  64'h504F_4E4D_4C4B_4A49),
    reg_row(CFG_PAT_16_23, 64'h0),
    reg_row(CFG_PAT_24_31, 64'hFFFF_FFFF_FFFF_FFFF),
    reg_row(CFG_LENGTH, 64'd3),
    text_row(8'h41, 1'b1),
    text_row(8'h42, 1'b0),
    text_row(8'h43, 1'b0),
    // "ABA" breaks the candidate; the second A opens a new one.
    text_row(8'h41, 1'b0),
    text_row(8'h42, 1'b0),
    text_row(8'h41, 1'b0),
    text_row(8'h42, 1'b0),
    text_row(8'h43, 1'b0),
    // A fresh text in the middle of a candidate starts over at position 0.
    text_row(8'h41, 1'b0),
    text_row(8'h41, 1'b1),
    text_row(8'h42, 1'b0),
    text_row(8'h43, 1'b0),
    // A length above 32 is clipped to 32; the candidate is then cut short.
    reg_row(CFG_LENGTH, 64'd63),
    text_row(8'h41, 1'b1),
    text_row(8'h42, 1'b0),
    text_row(8'h43, 1'b0),
    reg_row(CFG_LENGTH, 64'd4),
    text_row(8'h44, 1'b0),
    // Length drops to one while a candidate is open: a mismatch that hits
    // the first pattern byte is then a one-byte match.
    text_row(8'h41, 1'b0),
    text_row(8'h42, 1'b0),
    reg_row(CFG_LENGTH, 64'd1),
    text_row(8'h41, 1'b0),
    text_row(8'hFF, 1'b0)
  };

  function automatic logic [TextByteW-1:0] pattern_at(logic [4:0] i);
    return pattern_word[i[4:3]][{i[2:0], 3'b000} +: TextByteW];
  endfunction

  // Scan model: advances the copy of the scan state by one text byte and
  // tells whether the byte completes a match.
  function automatic bit scan_text_byte(input logic [TextByteW-1:0] b,
                                        input logic nt, output match_t hit);
    int unsigned       len;
    logic [MatchW-1:0] pos;
    bit                found;
    len = (pattern_len == 0) ? 1 :
          (pattern_len > MaxPatternDefault) ? MaxPatternDefault : pattern_len;
    found = 1'b0;
    hit = '0;
    if (nt) begin
      in_candidate = 1'b0;
      cmp_index = '0;
      candidate_pos = '0;
      next_pos = '0;
    end
    pos = next_pos;
    if (!in_candidate) begin
      if (b == pattern_at(5'd0)) begin
        if (len == 1) begin
          found = 1'b1;
          hit.match_start = pos;
        end else begin
          in_candidate = 1'b1;
          candidate_pos = pos;
          cmp_index = 5'd1;
        end
      end
    end else if (b != pattern_at(cmp_index)) begin
      // No backing up: only the first pattern byte is tried again.
      cmp_index = '0;
      if (b != pattern_at(5'd0)) begin
        in_candidate = 1'b0;
      end else if (len == 1) begin
        found = 1'b1;
        hit.match_start = pos;
        in_candidate = 1'b0;
      end else begin
        candidate_pos = pos;
        cmp_index = 5'd1;
      end
    end else if (cmp_index >= len - 1) begin
      found = 1'b1;
      hit.match_start = candidate_pos;
      cmp_index = '0;
      in_candidate = 1'b0;
    end else begin
      cmp_index = cmp_index + 5'd1;
    end
    // The position counter sticks at its top value.
    if (next_pos != '1) next_pos = next_pos + 1'b1;
    hit.match_end = pos;
    return found;
  endfunction

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #HalfPeriod clk_i = ~clk_i;
  end

  // Offers one text byte, after a random gap, and holds it until the block
  // takes it. The expectation is filed at the edge of the transfer.
  task automatic send_text(input logic [TextByteW-1:0] b, input logic nt,
                           input check_e chk = CHK_MODEL, input match_t typed = '0);
    match_t hit;
    bit     found;
    while ($urandom_range(99) < src_idle_pct) begin
      text_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    text_ch.valid <= 1'b1;
    text_ch.text_byte <= b;
    text_ch.new_text <= nt;
    @(posedge clk_i);
    while (!text_ch.ready) @(posedge clk_i);
    found = scan_text_byte(b, nt, hit);
    bytes_sent++;
    case (chk)
      CHK_MODEL: if (found) pending_matches.push_back(hit);
      CHK_MATCH: pending_matches.push_back(typed);
      default: ;
    endcase
  endtask

  // Stops the text, waits for every expected match, then lets the block settle
  // in case a byte without a result is still in flight.
  task automatic wait_quiet();
    text_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_matches.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // One register write. Valid drops for a cycle afterwards so that back to
  // back writes never lower and raise it in the same step.
  task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] d);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= d;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    case (idx)
      CFG_PAT_0_7, CFG_PAT_8_15, CFG_PAT_16_23, CFG_PAT_24_31: pattern_word[idx[1:0]] = d;
      CFG_LENGTH: pattern_len = d[LenW-1:0];
      default: ;
    endcase
    reg_writes++;
    cfg_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Picks a narrow alphabet and a pattern drawn from it. Pattern bytes past
  // the length are random over the full byte range.
  task automatic program_pattern(input int unsigned len);
    logic [CfgDataW-1:0] w;
    int unsigned         bi;
    alpha_base = TextByteW'($urandom_range(255));
    alpha_size = $urandom_range(1, 4);
    for (int wi = 0; wi < 4; wi++) begin
      for (int k = 0; k < BytesPerWord; k++) begin
        bi = wi * BytesPerWord + k;
        w[k*TextByteW +: TextByteW] = (bi < len) ?
            TextByteW'(alpha_base + $urandom_range(alpha_size - 1)) :
            TextByteW'($urandom_range(255));
      end
      write_reg(CFG_PAT_0_7 + CfgIndexW'(wi), w);
    end
    write_reg(CFG_LENGTH, CfgDataW'(len));
  endtask

  // Random text for one segment. The largest share of it is whole copies of
  // the pattern, so the scan gets past its first byte; the rest is cut-off
  // copies, alphabet noise and bytes over the full range. A fresh text now
  // and then breaks whatever is in progress.
  task automatic run_segment(input int unsigned len);
    int unsigned stop;
    int unsigned r;
    int unsigned cut;
    stop = bytes_sent + SegItems;
    while (bytes_sent < stop) begin
      r = $urandom_range(99);
      if (r < 45) begin
        for (int k = 0; k < len; k++) send_text(pattern_at(5'(k)), $urandom_range(99) < 3);
      end else if (r < 60) begin
        cut = $urandom_range(len - 1);
        for (int k = 0; k < cut; k++) send_text(pattern_at(5'(k)), $urandom_range(99) < 3);
        send_text(TextByteW'($urandom_range(255)), $urandom_range(99) < 3);
      end else if (r < 85) begin
        send_text(TextByteW'(alpha_base + $urandom_range(alpha_size - 1)),
                  $urandom_range(99) < 3);
      end else begin
        send_text(TextByteW'($urandom_range(255)), $urandom_range(99) < 3);
      end
    end
  endtask

  // Match receiver. It stalls at random, and on request holds ready low for
  // a long stretch so that the output buffer fills and the text side stalls.
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    match_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_left = HoldCycles;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        match_ch.ready <= 1'b0;
      end else begin
        match_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // Every match transfer is compared, field by field, with the oldest
  // expectation.
  always @(posedge clk_i) begin : check_matches
    match_t want;
    if (rst_ni && match_ch.valid && match_ch.ready) begin
      if (pending_matches.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected match, expected none, got start %0d end %0d",
                 $time, match_ch.match_start, match_ch.match_end);
      end else begin
        want = pending_matches.pop_front();
        matches_seen++;
        if (match_ch.match_start !== want.match_start) begin
          mismatches++;
          $display("%0t: match_start mismatch, expected %0d, got %0d",
                   $time, want.match_start, match_ch.match_start);
        end
        if (match_ch.match_end !== want.match_end) begin
          mismatches++;
          $display("%0t: match_end mismatch, expected %0d, got %0d",
                   $time, want.match_end, match_ch.match_end);
        end
      end
    end
  end

  // Watchdog: ends the run when no channel has moved a transfer for too long.
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk_i);
      if ((text_ch.valid && text_ch.ready) || (match_ch.valid && match_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("%0t: timeout, no transfer for %0d cycles", $time, WatchdogLimit);
    $display("FAIL");
    $finish;
  end

  // Main sequence: reset, directed table, then random segments under three
  // idle mixes, then drain and verdict.
  initial begin
    int unsigned seg_len;
    rst_ni <= 1'b0;
    text_ch.valid <= 1'b0;
    text_ch.text_byte <= '0;
    text_ch.new_text <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= '0;
    cfg_ch.data <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_REG) begin
        wait_quiet();
        write_reg(directed_rows[i].index, directed_rows[i].data);
      end else begin
        send_text(directed_rows[i].text_byte, directed_rows[i].new_text,
                  directed_rows[i].check,
                  '{match_start: directed_rows[i].first, match_end: directed_rows[i].last});
      end
    end

    // Three segments per idle mix: sender gaps light and receiver stalls
    // heavy, then the reverse, then no idling at all. The first segment uses
    // the longest pattern; the first segment of the last mix uses a one-byte
    // pattern and a long receiver hold, where matches come thickest.
    for (int seg = 0; seg < NumSegments; seg++) begin
      case (seg / 3)
        0: begin
          src_idle_pct = 30;
          sink_stall_pct = 72;
        end
        1: begin
          src_idle_pct = 72;
          sink_stall_pct = 30;
        end
        default: begin
          src_idle_pct = 0;
          sink_stall_pct = 0;
        end
      endcase
      seg_len = (seg == 0) ? MaxPatternDefault : (seg == 6) ? 1 : $urandom_range(1, 8);
      wait_quiet();
      program_pattern(seg_len);
      if (seg == 6) hold_req = 1'b1;
      run_segment(seg_len);
    end

    wait_quiet();
    if (pending_matches.size() != 0) begin
      mismatches += pending_matches.size();
      $display("%0t: %0d expected matches never arrived", $time, pending_matches.size());
    end

    $display("Scanned %0d text bytes with %0d register writes; %0d matches compared.",
             bytes_sent, reg_writes, matches_seen);
    $display("Covered pattern lengths 1 to 8 and 32, clipped and zero lengths,",
             " mid-candidate length changes, fresh texts and a long receiver hold.");
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/spms_pkg.sv
rtl/spms_text_if.sv
rtl/spms_match_if.sv
rtl/spms_cfg_if.sv
rtl/stream_pattern_match_scanner_core.sv
tb/stream_pattern_match_scanner_core_test.sv
